FILE: hdl/mrbl_pkg.sv
// Package for the marker ring border line scanner.
// Holds color, status and area codes and default sizes; no dependencies.
`default_nettype none
package mrbl_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int COLOR_W = 3;
	localparam int DIR_W = 3;
	localparam int STATUS_W = 3;
	localparam int COUNT_W = 8;
	localparam logic [COUNT_W-1:0] MAX_INVALID_RST = 8'd10;

	localparam logic [COLOR_W-1:0] COL_NONE = 3'd0;
	localparam logic [COLOR_W-1:0] COL_BLUE = 3'd1;
	localparam logic [COLOR_W-1:0] COL_RED = 3'd2;
	localparam logic [COLOR_W-1:0] COL_GREEN = 3'd3;
	localparam logic [COLOR_W-1:0] COL_BLACK = 3'd4;
	localparam logic [COLOR_W-1:0] COL_WHITE = 3'd5;

	localparam logic [STATUS_W-1:0] ST_VALID = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_BLUE_FIRST = 3'd1;
	localparam logic [STATUS_W-1:0] ST_GREEN_AFTER_BLUE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BLUE_AFTER_RED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_OUTER = 3'd4;

	typedef enum logic [4:0] {
		AREA_INITIAL = 5'b00001,
		AREA_BLUE = 5'b00010,
		AREA_RED = 5'b00100,
		AREA_GREEN = 5'b01000,
		AREA_OUTSIDE = 5'b10000
	} area_t;

endpackage
`default_nettype wire

FILE: hdl/marker_ring_border_line_scanner.sv
// Marker ring border line scanner: top level with the line state machine.
// Depends on mrbl_pkg for codes and default sizes.
`default_nettype none

// One classified pixel is taken per cycle on the s_ side unless a pixel
// that concludes a line waits on a stalled result; the line state is
// updated from the input register in a single pass, so the sustained rate
// is one item per clock while results are taken, and each result is held
// in the output register for the m_ side. A result item appears only when
// a line concludes (reject, too many unclassified pixels, or the last
// pixel); pixels before a first pixel or after a line concluded are dropped.
// The output register holds a result while m_tready is low, and the input
// side keeps accepting pixels that do not conclude a line during that time.
module marker_ring_border_line_scanner #(
	parameter int COORD_BITS = mrbl_pkg::COORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [mrbl_pkg::COUNT_W-1:0] cfg_wr_data,
	input wire logic s_tvalid,
	output logic s_tready,
	// color_code, pixel_x, pixel_y, direction
	input wire logic [((2*mrbl_pkg::COLOR_W+2*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// first_pixel
	input wire logic [0:0] s_tuser,
	input wire logic s_tlast,
	output logic m_tvalid,
	input wire logic m_tready,
	// line_direction, line_status, inner_found, inner_x, inner_y, outer_x, outer_y
	output logic [((2*mrbl_pkg::STATUS_W+1+4*COORD_BITS+7)/8)*8-1:0] m_tdata
);
	import mrbl_pkg::*;

	localparam int OUT_USED = DIR_W + STATUS_W + 1 + 4 * COORD_BITS;
	localparam int OUT_W = ((OUT_USED + 7) / 8) * 8;

	logic [COUNT_W-1:0] max_inv_q;

	logic valid_s1;
	logic [COLOR_W-1:0] color_s1;
	logic [COORD_BITS-1:0] px_s1, py_s1;
	logic [DIR_W-1:0] dir_s1;
	logic first_s1, last_s1;

	area_t area_q, area_n, eff_area;
	logic [COLOR_W-1:0] prev_q, prev_n, eff_prev;
	logic known_q, known_n, eff_known;
	logic [COORD_BITS-1:0] run_x_q, run_y_q, run_x_n, run_y_n;
	logic [COUNT_W-1:0] inv_q, inv_n, eff_inv;
	logic [COORD_BITS-1:0] inner_x_q, inner_y_q, inner_x_n, inner_y_n;
	logic [COORD_BITS-1:0] outer_x_q, outer_y_q, outer_x_n, outer_y_n;
	logic [1:0] flags_q, flags_n, eff_flags;
	logic concluded_q, concluded_n;

	logic res;
	logic [STATUS_W-1:0] status;
	logic s1_go;
	logic m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_inv_q <= MAX_INVALID_RST;
		end else if (cfg_wr_en) begin
			max_inv_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			color_s1 <= s_tdata[COLOR_W-1:0];
			px_s1 <= s_tdata[COLOR_W +: COORD_BITS];
			py_s1 <= s_tdata[COLOR_W+COORD_BITS +: COORD_BITS];
			dir_s1 <= s_tdata[COLOR_W+2*COORD_BITS +: DIR_W];
			first_s1 <= s_tuser[0];
			last_s1 <= s_tlast;
		end
	end

	always_comb begin
		eff_area = first_s1 ? AREA_INITIAL : area_q;
		eff_prev = first_s1 ? COL_NONE : prev_q;
		eff_known = first_s1 ? 1'b0 : known_q;
		eff_inv = first_s1 ? '0 : inv_q;
		eff_flags = first_s1 ? 2'b00 : flags_q;

		area_n = eff_area;
		prev_n = eff_prev;
		known_n = eff_known;
		inv_n = eff_inv;
		flags_n = eff_flags;
		run_x_n = first_s1 ? '0 : run_x_q;
		run_y_n = first_s1 ? '0 : run_y_q;
		inner_x_n = first_s1 ? '0 : inner_x_q;
		inner_y_n = first_s1 ? '0 : inner_y_q;
		outer_x_n = first_s1 ? '0 : outer_x_q;
		outer_y_n = first_s1 ? '0 : outer_y_q;
		concluded_n = first_s1 ? 1'b0 : concluded_q;
		res = 1'b0;
		status = ST_VALID;

		if (valid_s1 && (first_s1 || !concluded_q)) begin
			if (color_s1 == COL_NONE && eff_inv >= max_inv_q) begin
				res = 1'b1;
				status = eff_flags[1] ? ST_VALID : ST_NO_OUTER;
			end else begin
				if (color_s1 == COL_NONE) begin
					inv_n = eff_inv + 1'b1;
				end
				if (!eff_known || color_s1 != eff_prev) begin
					prev_n = color_s1;
					known_n = 1'b1;
					run_x_n = px_s1;
					run_y_n = py_s1;
				end else begin
					case (eff_area)
						AREA_INITIAL: begin
							if (color_s1 != COL_BLUE) begin
								res = 1'b1;
								status = ST_NOT_BLUE_FIRST;
							end else begin
								area_n = AREA_BLUE;
							end
						end
						AREA_BLUE: begin
							if (color_s1 == COL_RED) begin
								inner_x_n = run_x_n;
								inner_y_n = run_y_n;
								flags_n[0] = 1'b1;
								area_n = AREA_RED;
							end else if (color_s1 == COL_GREEN) begin
								res = 1'b1;
								status = ST_GREEN_AFTER_BLUE;
							end
						end
						AREA_RED: begin
							if (color_s1 == COL_BLUE) begin
								res = 1'b1;
								status = ST_BLUE_AFTER_RED;
							end else if (color_s1 inside {COL_GREEN, COL_NONE,
									COL_BLACK, COL_WHITE}) begin
								outer_x_n = run_x_n;
								outer_y_n = run_y_n;
								flags_n[1] = 1'b1;
								area_n = (color_s1 == COL_GREEN) ? AREA_GREEN : AREA_OUTSIDE;
							end
						end
						default: begin
						end
					endcase
				end
				if (!res && last_s1) begin
					res = 1'b1;
					status = flags_n[1] ? ST_VALID : ST_NO_OUTER;
				end
			end
			if (res) begin
				concluded_n = 1'b1;
			end
		end
	end

	assign s1_go = valid_s1 && (!res || !m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= AREA_INITIAL;
			prev_q <= COL_NONE;
			known_q <= 1'b0;
			inv_q <= '0;
			flags_q <= 2'b00;
			concluded_q <= 1'b1;
		end else if (s1_go) begin
			area_q <= area_n;
			prev_q <= prev_n;
			known_q <= known_n;
			inv_q <= inv_n;
			flags_q <= flags_n;
			concluded_q <= concluded_n;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			run_x_q <= run_x_n;
			run_y_q <= run_y_n;
			inner_x_q <= inner_x_n;
			inner_y_q <= inner_y_n;
			outer_x_q <= outer_x_n;
			outer_y_q <= outer_y_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s1_go && res) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res) begin
			m_tdata_q <= OUT_W'({outer_y_n, outer_x_n, inner_y_n, inner_x_n,
				flags_n[0], status, dir_s1});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule
`default_nettype wire

FILE: hdl/mrbl_checker.sv
// Port-level checker for the marker ring border line scanner, and its bind.
// Depends on mrbl_pkg for the status codes and default sizes.
`default_nettype none
module mrbl_checker #(
	parameter int COORD_BITS = mrbl_pkg::COORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [((2*mrbl_pkg::STATUS_W+1+4*COORD_BITS+7)/8)*8-1:0] m_tdata
);
	import mrbl_pkg::*;

	localparam int ST_LSB = DIR_W;
	localparam int FOUND_BIT = DIR_W + STATUS_W;
	localparam int INNER_LSB = FOUND_BIT + 1;

	logic [STATUS_W-1:0] st;
	logic found;
	logic [2*COORD_BITS-1:0] inner_xy;

	assign st = m_tdata[ST_LSB +: STATUS_W];
	assign found = m_tdata[FOUND_BIT];
	assign inner_xy = m_tdata[INNER_LSB +: 2*COORD_BITS];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result item changed while stalled.");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("Result item shown during reset.");

	a_valid_needs_inner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == ST_VALID |-> found)
		else $error("Valid line without an inner border.");

	a_inner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !found |-> inner_xy == '0)
		else $error("Inner border position set but not found.");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> st == ST_VALID || st == ST_NOT_BLUE_FIRST ||
			st == ST_GREEN_AFTER_BLUE || st == ST_BLUE_AFTER_RED || st == ST_NO_OUTER)
		else $error("Unknown line status.");

endmodule

bind marker_ring_border_line_scanner mrbl_checker #(
	.COORD_BITS(COORD_BITS)
) u_mrbl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the marker ring border line scanner.
// Needs mrbl_pkg and marker_ring_border_line_scanner from hdl; reads no files.
// A short table of scan lines runs first, then random lines under several limits.
`default_nettype none
module testbench;
	import mrbl_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int S_W = ((2*COLOR_W+2*CB+7)/8)*8;
	localparam int M_W = ((2*STATUS_W+1+4*CB+7)/8)*8;
	localparam logic [COLOR_W-1:0] COL_OTHER_A = 3'd6;
	localparam logic [COLOR_W-1:0] COL_OTHER_B = 3'd7;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [DIR_W-1:0] dir;
		logic first;
		logic last;
	} pixel_t;

	typedef struct packed {
		logic [DIR_W-1:0] dir;
		logic [STATUS_W-1:0] status;
		logic inner_found;
		logic [CB-1:0] inner_x;
		logic [CB-1:0] inner_y;
		logic [CB-1:0] outer_x;
		logic [CB-1:0] outer_y;
	} line_result_t;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_TYPED} row_kind_e;

	typedef struct packed {
		pixel_t px;
		row_kind_e kind;
		line_result_t want;
	} stim_row_t;

	localparam line_result_t NO_LINE = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en = 1'b0;
	logic [COUNT_W-1:0] cfg_wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_W-1:0] m_tdata;

	marker_ring_border_line_scanner dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	// Line scanner state as the block should hold it.
	area_t scan_area = AREA_INITIAL;
	logic [COLOR_W-1:0] last_color = COL_NONE;
	logic last_color_valid = 1'b0;
	logic [CB-1:0] run_x = '0, run_y = '0;
	logic [COUNT_W-1:0] bad_count = '0;
	logic [COUNT_W-1:0] max_bad = MAX_INVALID_RST;
	logic [CB-1:0] ring_in_x = '0, ring_in_y = '0, ring_out_x = '0, ring_out_y = '0;
	logic inner_seen = 1'b0, outer_seen = 1'b0;
	logic line_done = 1'b1;

	line_result_t awaited_lines[$];
	int unsigned errors = 0;
	int unsigned analysed = 0;
	int unsigned sent = 0;
	int unsigned lines_built = 0;
	int unsigned status_seen[5] = '{0, 0, 0, 0, 0};

	bit gaps_on = 1'b1;
	int burst_left = 0;

	pixel_t line_buf[$];
	logic [CB-1:0] walk_x, walk_y, walk_dx, walk_dy;
	logic [DIR_W-1:0] walk_dir;
	bit noise_none;

	function automatic bit close_line(input logic [DIR_W-1:0] dir,
			input logic [STATUS_W-1:0] status, output line_result_t r);
		line_done = 1'b1;
		r.dir = dir;
		r.status = status;
		r.inner_found = inner_seen;
		r.inner_x = ring_in_x;
		r.inner_y = ring_in_y;
		r.outer_x = ring_out_x;
		r.outer_y = ring_out_y;
		return 1'b1;
	endfunction

	function automatic bit scan_pixel(input pixel_t p, output line_result_t r);
		r = '0;
		if (p.first) begin
			scan_area = AREA_INITIAL;
			last_color = COL_NONE;
			last_color_valid = 1'b0;
			run_x = '0;
			run_y = '0;
			bad_count = '0;
			ring_in_x = '0;
			ring_in_y = '0;
			ring_out_x = '0;
			ring_out_y = '0;
			inner_seen = 1'b0;
			outer_seen = 1'b0;
			line_done = 1'b0;
		end
		if (line_done)
			return 1'b0;
		if (p.color == COL_NONE) begin
			if (bad_count >= max_bad)
				return close_line(p.dir, outer_seen ? ST_VALID : ST_NO_OUTER, r);
			bad_count++;
		end
		if (!last_color_valid || p.color != last_color) begin
			last_color = p.color;
			last_color_valid = 1'b1;
			run_x = p.x;
			run_y = p.y;
		end else begin
			case (scan_area)
				AREA_INITIAL: begin
					if (p.color != COL_BLUE)
						return close_line(p.dir, ST_NOT_BLUE_FIRST, r);
					scan_area = AREA_BLUE;
				end
				AREA_BLUE: begin
					if (p.color == COL_RED) begin
						ring_in_x = run_x;
						ring_in_y = run_y;
						inner_seen = 1'b1;
						scan_area = AREA_RED;
					end else if (p.color == COL_GREEN) begin
						return close_line(p.dir, ST_GREEN_AFTER_BLUE, r);
					end
				end
				AREA_RED: begin
					if (p.color == COL_BLUE)
						return close_line(p.dir, ST_BLUE_AFTER_RED, r);
					if (p.color == COL_GREEN || p.color == COL_NONE ||
							p.color == COL_BLACK || p.color == COL_WHITE) begin
						ring_out_x = run_x;
						ring_out_y = run_y;
						outer_seen = 1'b1;
						scan_area = (p.color == COL_GREEN) ? AREA_GREEN : AREA_OUTSIDE;
					end
				end
				default: begin
				end
			endcase
		end
		if (p.last)
			return close_line(p.dir, outer_seen ? ST_VALID : ST_NO_OUTER, r);
		return 1'b0;
	endfunction

	task automatic send_pixel(input pixel_t p, input row_kind_e kind, input line_result_t want);
		line_result_t got;
		bit made;
		if (gaps_on && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_W-2*COLOR_W-2*CB){1'b0}}, p.dir, p.y, p.x, p.color};
		s_tuser <= p.first;
		s_tlast <= p.last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		if (!line_done || p.first)
			analysed++;
		made = scan_pixel(p, got);
		if (kind == ROW_TYPED)
			awaited_lines.push_back(want);
		else if (kind == ROW_PREDICT && made)
			awaited_lines.push_back(got);
	endtask

	task automatic settle();
		int waited;
		s_tvalid <= 1'b0;
		for (waited = 0; waited < 20000 && awaited_lines.size() != 0; waited++)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_limit(input logic [COUNT_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		max_bad = value;
	endtask

	task automatic walk_run(input logic [COLOR_W-1:0] color, input int count);
		pixel_t p;
		for (int i = 0; i < count; i++) begin
			p = '{color, walk_x, walk_y, walk_dir, 1'b0, 1'b0};
			if ($urandom_range(0, 4) == 0)
				p.dir = DIR_W'($urandom_range(0, 7));
			line_buf.push_back(p);
			walk_x += walk_dx;
			walk_y += walk_dy;
			if ($urandom_range(0, 9) == 0) begin
				walk_x = CB'($urandom);
				walk_y = CB'($urandom);
			end
			if (noise_none && $urandom_range(0, 19) == 0) begin
				p.color = COL_NONE;
				p.x = walk_x;
				p.y = walk_y;
				line_buf.push_back(p);
			end
		end
	endtask

	task automatic make_line();
		int shape;
		logic [COLOR_W-1:0] outer;
		line_buf.delete();
		walk_x = CB'($urandom);
		walk_y = CB'($urandom);
		walk_dx = CB'($urandom_range(0, 2)) - 1'b1;
		walk_dy = CB'($urandom_range(0, 2)) - 1'b1;
		walk_dir = DIR_W'($urandom_range(0, 7));
		noise_none = ($urandom_range(0, 3) == 0);
		shape = $urandom_range(0, 9);
		case (shape)
			0, 1, 2, 3, 4, 5: begin
				case ($urandom_range(0, 3))
					0: outer = COL_GREEN;
					1: outer = COL_BLACK;
					2: outer = COL_WHITE;
					default: outer = COL_NONE;
				endcase
				walk_run(COL_BLUE, $urandom_range(1, 4));
				walk_run(COL_RED, $urandom_range(1, 4));
				walk_run(outer, $urandom_range(1, 3));
				repeat ($urandom_range(0, 3))
					walk_run(COLOR_W'($urandom_range(0, 7)), $urandom_range(1, 2));
			end
			6: begin
				repeat ($urandom_range(2, 8))
					walk_run(COLOR_W'($urandom_range(0, 7)), $urandom_range(1, 3));
			end
			7: begin
				walk_run(COL_BLUE, $urandom_range(2, 3));
				if ($urandom_range(0, 1) == 0) begin
					walk_run(COL_RED, $urandom_range(2, 3));
					walk_run(COL_BLUE, $urandom_range(1, 3));
				end else begin
					walk_run(COL_GREEN, $urandom_range(1, 3));
				end
			end
			8: begin
				walk_run(COL_BLUE, $urandom_range(2, 3));
				walk_run(COL_RED, $urandom_range(2, 3));
				walk_run(COL_NONE, $urandom_range(1, 14));
				walk_run(COLOR_W'($urandom_range(0, 7)), $urandom_range(0, 3));
			end
			default: walk_run(COLOR_W'($urandom_range(0, 7)), $urandom_range(1, 4));
		endcase
		if (shape != 9)
			line_buf[0].first = 1'b1;
		if ($urandom_range(0, 19) == 0)
			line_buf[$urandom_range(0, line_buf.size() - 1)].first = 1'b1;
		if ($urandom_range(0, 6) != 0)
			line_buf[$].last = 1'b1;
		if ($urandom_range(0, 19) == 0)
			line_buf[$urandom_range(0, line_buf.size() - 1)].last = 1'b1;
		lines_built++;
	endtask

	// Receiver readiness follows a 16-bit pattern that is redrawn at random.
	int ready_pos = 0;
	logic [15:0] ready_pattern = 16'hFFFF;
	always @(posedge clk) begin
		if (ready_pos == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern = 16'hFFFF;
				1, 2: ready_pattern = 16'($urandom);
				default: ready_pattern = 16'($urandom & $urandom);
			endcase
		end
		m_tready <= ready_pattern[ready_pos[3:0]];
		ready_pos = (ready_pos + 1) % 64;
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		line_result_t want;
		line_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.dir = m_tdata[2:0];
			got.status = m_tdata[5:3];
			got.inner_found = m_tdata[6];
			got.inner_x = m_tdata[7 +: CB];
			got.inner_y = m_tdata[7+CB +: CB];
			got.outer_x = m_tdata[7+2*CB +: CB];
			got.outer_y = m_tdata[7+3*CB +: CB];
			if (awaited_lines.size() == 0) begin
				$error("line result with none expected: status %0d, direction %0d",
					got.status, got.dir);
				errors++;
			end else begin
				want = awaited_lines.pop_front();
				if (want.status < 5)
					status_seen[want.status]++;
				check_field("line_direction", 32'(want.dir), 32'(got.dir));
				check_field("line_status", 32'(want.status), 32'(got.status));
				check_field("inner_found", 32'(want.inner_found), 32'(got.inner_found));
				check_field("inner_x", 32'(want.inner_x), 32'(got.inner_x));
				check_field("inner_y", 32'(want.inner_y), 32'(got.inner_y));
				check_field("outer_x", 32'(want.outer_x), 32'(got.outer_x));
				check_field("outer_y", 32'(want.outer_y), 32'(got.outer_y));
			end
		end
	end

	initial begin
		#2000000;
		$error("run did not finish in time");
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		stim_row_t opening_rows[28];
		logic [COUNT_W-1:0] limit_plan[7];
		logic [COUNT_W-1:0] limit_value;
		int unsigned phase_start;
		bit paused;

		arst_n <= 1'b0;
		opening_rows = '{
			'{'{COL_RED, 12'd4095, 12'd4095, 3'd7, 1'b0, 1'b1}, ROW_SILENT, NO_LINE},
			'{'{COL_GREEN, 12'd0, 12'd0, 3'd0, 1'b1, 1'b0}, ROW_SILENT, NO_LINE},
			'{'{COL_GREEN, 12'd1, 12'd0, 3'd5, 1'b0, 1'b0}, ROW_TYPED,
				'{3'd5, ST_NOT_BLUE_FIRST, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0}},
			'{'{COL_BLUE, 12'd2, 12'd0, 3'd3, 1'b0, 1'b1}, ROW_SILENT, NO_LINE},
			'{'{COL_BLUE, 12'd0, 12'd0, 3'd0, 1'b1, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_BLUE, 12'd1, 12'd1, 3'd1, 1'b0, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_RED, 12'd4095, 12'd4095, 3'd2, 1'b0, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_RED, 12'd4094, 12'd4094, 3'd3, 1'b0, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_OTHER_B, 12'd4093, 12'd4093, 3'd4, 1'b0, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_OTHER_B, 12'd4092, 12'd4092, 3'd5, 1'b0, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_WHITE, 12'd4095, 12'd0, 3'd6, 1'b0, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_WHITE, 12'd0, 12'd4095, 3'd0, 1'b0, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_BLUE, 12'd2048, 12'd2048, 3'd7, 1'b0, 1'b1}, ROW_TYPED,
				'{3'd7, ST_VALID, 1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd0}},
			'{'{COL_BLUE, 12'd100, 12'd200, 3'd2, 1'b1, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_BLUE, 12'd101, 12'd201, 3'd2, 1'b0, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_RED, 12'd102, 12'd202, 3'd2, 1'b0, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_RED, 12'd103, 12'd203, 3'd2, 1'b0, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_BLUE, 12'd104, 12'd204, 3'd2, 1'b0, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_BLUE, 12'd105, 12'd205, 3'd4, 1'b0, 1'b0}, ROW_TYPED,
				'{3'd4, ST_BLUE_AFTER_RED, 1'b1, 12'd102, 12'd202, 12'd0, 12'd0}},
			'{'{COL_BLUE, 12'd7, 12'd7, 3'd1, 1'b1, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_BLUE, 12'd8, 12'd8, 3'd1, 1'b0, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_GREEN, 12'd9, 12'd9, 3'd1, 1'b0, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_GREEN, 12'd10, 12'd10, 3'd6, 1'b0, 1'b0}, ROW_TYPED,
				'{3'd6, ST_GREEN_AFTER_BLUE, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0}},
			'{'{COL_BLUE, 12'd1, 12'd2, 3'd3, 1'b1, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_OTHER_A, 12'd2, 12'd3, 3'd0, 1'b1, 1'b0}, ROW_PREDICT, NO_LINE},
			'{'{COL_OTHER_A, 12'd3, 12'd4, 3'd1, 1'b0, 1'b0}, ROW_TYPED,
				'{3'd1, ST_NOT_BLUE_FIRST, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0}},
			'{'{COL_BLACK, 12'd0, 12'd0, 3'd2, 1'b1, 1'b1}, ROW_TYPED,
				'{3'd2, ST_NO_OUTER, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0}},
			'{'{COL_NONE, 12'd5, 12'd5, 3'd3, 1'b1, 1'b1}, ROW_PREDICT, NO_LINE}
		};
		limit_plan = '{8'd10, 8'd0, 8'd255, 8'd1, 8'd2, 8'd0, 8'd4};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[i])
			send_pixel(opening_rows[i].px, opening_rows[i].kind, opening_rows[i].want);

		for (int phase = 0; phase < 7; phase++) begin
			settle();
			limit_value = (phase == 5) ? COUNT_W'($urandom_range(0, 255)) : limit_plan[phase];
			set_limit(limit_value);
			gaps_on = (phase % 3 != 1);
			burst_left = 0;
			paused = 1'b0;
			phase_start = sent;
			if (limit_value == 8'd255) begin
				line_buf.delete();
				noise_none = 1'b0;
				walk_dx = 12'd1;
				walk_dy = '0;
				walk_dir = DIR_W'($urandom_range(0, 7));
				walk_run(COL_BLUE, 2);
				walk_run(COL_NONE, 260);
				line_buf[0].first = 1'b1;
				line_buf[$].last = 1'b1;
				lines_built++;
				foreach (line_buf[i])
					send_pixel(line_buf[i], ROW_PREDICT, NO_LINE);
				phase_start = sent;
			end
			while (sent - phase_start < 145) begin
				if (phase == 3 && !paused && sent - phase_start >= 72) begin
					settle();
					paused = 1'b1;
				end
				make_line();
				foreach (line_buf[i])
					send_pixel(line_buf[i], ROW_PREDICT, NO_LINE);
			end
		end

		settle();
		if (awaited_lines.size() != 0) begin
			$error("%0d line results never arrived", awaited_lines.size());
			errors++;
		end
		$display("Sent %0d pixels, %0d analysed, over %0d random lines and 7 limits.",
			sent, analysed, lines_built);
		$display("Line results: %0d valid, %0d not blue first, %0d green after blue,",
			status_seen[0], status_seen[1], status_seen[2]);
		$display("  %0d blue after red, %0d no outer border.",
			status_seen[3], status_seen[4]);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
